// ===== hw/rtl/krvt_pkg.sv =====
package krvt_pkg;

    localparam int DATA_W = 64;
    localparam int REG_IDX_W = 5;
    localparam int IMM_W = 20;
    localparam int LUI_SHIFT = 12;
    localparam logic [REG_IDX_W-1:0] REG_A0 = 5'd10;

    localparam logic [1:0] OP_EXEC  = 2'd0;
    localparam logic [1:0] OP_MERGE = 2'd1;
    localparam logic [1:0] OP_FRESH = 2'd2;
    localparam logic [1:0] OP_WRITE = 2'd3;

    localparam logic [3:0] OPC_ADDI  = 4'd0;
    localparam logic [3:0] OPC_LUI   = 4'd1;
    localparam logic [3:0] OPC_LD    = 4'd2;
    localparam logic [3:0] OPC_SD    = 4'd3;
    localparam logic [3:0] OPC_BEQ   = 4'd4;
    localparam logic [3:0] OPC_JAL   = 4'd5;
    localparam logic [3:0] OPC_JALR  = 4'd6;
    localparam logic [3:0] OPC_ECALL = 4'd7;
    localparam logic [3:0] OPC_ADD   = 4'd8;
    localparam logic [3:0] OPC_SUB   = 4'd9;
    localparam logic [3:0] OPC_MUL   = 4'd10;
    localparam logic [3:0] OPC_DIVU  = 4'd11;
    localparam logic [3:0] OPC_REMU  = 4'd12;
    localparam logic [3:0] OPC_SLTU  = 4'd13;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the input beat
        logic fetch_a;    // latch operand a from the file
        logic fetch_b;    // latch operand b from the file
        logic mul_start;  // begin multiply
        logic mul_step;   // one partial product
        logic div_start;  // begin divide
        logic div_step;   // one quotient bit
        logic commit;     // apply the item to the file
        logic fresh_step; // clear one entry
        logic out_load;   // load the result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic [3:0] opcode;
        logic       mul_done;
        logic       div_done;
        logic       fresh_done;
    } t_stat;

endpackage

// ===== hw/rtl/krvt_ram.sv =====
module krvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/krvt_ctrl.sv =====
module krvt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  krvt_pkg::t_stat  i_stat,
    output krvt_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDA   = 4'd1;
    localparam logic [3:0] S_RDB   = 4'd2;
    localparam logic [3:0] S_OPS   = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_COMMIT= 4'd6;
    localparam logic [3:0] S_RDOUT = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_FRESH = 4'd9;
    localparam logic [3:0] S_WAIT  = 4'd10;
    localparam logic [3:0] S_INIT  = 4'd11;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid;
        o_cmd = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_INIT: begin
                // clear the value RAM after reset
                o_cmd.fresh_step = 1'b1;
                if (i_stat.fresh_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                // operand a read was issued with the load
                o_cmd.fetch_a = 1'b1;
                n_state = S_RDB;
            end
            S_RDB: begin
                o_cmd.fetch_b = 1'b1;
                n_state = S_OPS;
            end
            S_OPS: begin
                if (i_stat.op == krvt_pkg::OP_FRESH) begin
                    n_state = S_FRESH;
                end else if (i_stat.op == krvt_pkg::OP_EXEC &&
                             i_stat.opcode == krvt_pkg::OPC_MUL) begin
                    o_cmd.mul_start = 1'b1;
                    n_state = S_MUL;
                end else if (i_stat.op == krvt_pkg::OP_EXEC &&
                             (i_stat.opcode == krvt_pkg::OPC_DIVU ||
                              i_stat.opcode == krvt_pkg::OPC_REMU)) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_MUL: begin
                if (i_stat.mul_done) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.mul_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_RDOUT;
            end
            S_FRESH: begin
                o_cmd.fresh_step = 1'b1;
                if (i_stat.fresh_done) begin
                    n_state = S_RDOUT;
                end
            end
            S_RDOUT: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/krvt_dp.sv =====
module krvt_dp #(
    parameter int NUM_REGS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  krvt_pkg::t_cmd       i_cmd,
    output krvt_pkg::t_stat      o_stat,
    input  logic [111:0]         i_in_data,
    output logic [71:0]          o_out_data
);

    localparam int AW = $clog2(NUM_REGS);
    localparam int DW = krvt_pkg::DATA_W;
    localparam int RW = krvt_pkg::REG_IDX_W;

    // captured beat
    logic [1:0]    r_op;
    logic [3:0]    r_opc;
    logic [RW-1:0] r_rd, r_rs1, r_rs2, r_tr;
    logic [DW-1:0] r_imm, r_inc_val;
    logic          r_inc_known;

    logic [NUM_REGS-1:0] r_known, n_known;
    logic [DW-1:0] r_a, r_b;
    logic          r_ka, r_kb;

    // multiply: 4 partial products of 64x16
    logic [DW-1:0] r_mul_acc;
    logic [1:0]    r_mul_cnt;
    logic          r_mul_done;
    // divide: restoring, one bit per cycle
    logic [DW-1:0] r_quo, r_rem;
    logic [6:0]    r_div_cnt;
    logic [DW:0]   w_div_trial, w_div_diff;

    logic [AW:0]   r_fresh_idx;

    logic [RW-1:0] w_raddr_sel;
    logic          w_ram_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [DW-1:0] w_wdata, w_rdata;

    // result
    logic [RW-1:0] r_touch;
    logic          r_chg, n_chg;
    logic [71:0]   r_out;

    function automatic logic in_range(input logic [RW-1:0] r);
        in_range = ({{(32-RW){1'b0}}, r} < NUM_REGS);
    endfunction

    function automatic logic [AW-1:0] idx(input logic [RW-1:0] r);
        logic [RW+AW-1:0] ext;
        ext = {{AW{1'b0}}, r};
        idx = ext[AW-1:0];
    endfunction

    // read address sequencing: operand a on load (target reg for non-execute)
    always_comb begin
        if (i_cmd.load) begin
            w_raddr_sel = (i_in_data[1:0] == krvt_pkg::OP_EXEC) ? i_in_data[15:11]
                                                               : i_in_data[45:41];
        end else if (i_cmd.fetch_a) begin
            w_raddr_sel = r_rs2;
        end else if (r_op == krvt_pkg::OP_EXEC) begin
            w_raddr_sel = r_rd;
        end else begin
            w_raddr_sel = r_tr;
        end
    end
    assign w_raddr = idx(w_raddr_sel);

    logic          w_we;
    logic [RW-1:0] w_wreg;
    logic [DW-1:0] w_res;
    logic          w_forget;
    logic [RW-1:0] w_freg;
    logic          w_both;

    assign w_both = r_ka && r_kb;

    always_comb begin
        w_we = 1'b0;
        w_wreg = r_rd;
        w_res = '0;
        w_forget = 1'b0;
        w_freg = r_rd;
        n_chg = 1'b0;
        case (r_op)
            krvt_pkg::OP_EXEC: begin
                case (r_opc)
                    krvt_pkg::OPC_ADDI: begin
                        if (r_ka) begin
                            w_we = 1'b1;
                            w_res = r_a + r_imm;
                        end else begin
                            w_forget = 1'b1;
                        end
                    end
                    krvt_pkg::OPC_LUI: begin
                        w_we = 1'b1;
                        w_res = r_imm << krvt_pkg::LUI_SHIFT;
                    end
                    krvt_pkg::OPC_LD, krvt_pkg::OPC_JAL, krvt_pkg::OPC_JALR:
                        w_forget = 1'b1;
                    krvt_pkg::OPC_ECALL: begin
                        w_forget = 1'b1;
                        w_freg = krvt_pkg::REG_A0;
                    end
                    krvt_pkg::OPC_ADD, krvt_pkg::OPC_SUB, krvt_pkg::OPC_MUL,
                    krvt_pkg::OPC_SLTU: begin
                        if (w_both) begin
                            w_we = 1'b1;
                            case (r_opc)
                                krvt_pkg::OPC_ADD: w_res = r_a + r_b;
                                krvt_pkg::OPC_SUB: w_res = r_a - r_b;
                                krvt_pkg::OPC_MUL: w_res = r_mul_acc;
                                default: w_res = {{(DW-1){1'b0}}, r_a < r_b};
                            endcase
                        end else begin
                            w_forget = 1'b1;
                        end
                    end
                    krvt_pkg::OPC_DIVU, krvt_pkg::OPC_REMU: begin
                        if (!w_both) begin
                            w_forget = 1'b1;
                        end else if (r_b != '0) begin
                            w_we = 1'b1;
                            w_res = (r_opc == krvt_pkg::OPC_DIVU) ? r_quo : r_rem;
                        end
                    end
                    default: ;
                endcase
            end
            krvt_pkg::OP_MERGE: begin
                // r_a holds the target entry here
                w_freg = r_tr;
                if (r_tr != '0 && r_ka && (!r_inc_known || r_inc_val != r_a)) begin
                    w_forget = 1'b1;
                    n_chg = 1'b1;
                end
            end
            krvt_pkg::OP_WRITE: begin
                w_wreg = r_tr;
                w_freg = r_tr;
                w_res = r_inc_val;
                w_we = r_inc_known;
                w_forget = !r_inc_known;
            end
            default: ;
        endcase
    end

    assign w_ram_we = i_cmd.fresh_step ||
                      (i_cmd.commit && w_we && w_wreg != '0 && in_range(w_wreg));
    assign w_waddr = i_cmd.fresh_step ? r_fresh_idx[AW-1:0] : idx(w_wreg);
    assign w_wdata = i_cmd.fresh_step ? '0 : w_res;

    krvt_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_file (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_known = r_known;
        if (i_cmd.commit) begin
            if (w_ram_we) begin
                n_known[idx(w_wreg)] = 1'b1;
            end
            if (w_forget && w_freg != '0 && in_range(w_freg)) begin
                n_known[idx(w_freg)] = 1'b0;
            end
        end
        if (i_cmd.fresh_step) begin
            n_known = {{(NUM_REGS-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= {{(NUM_REGS-1){1'b0}}, 1'b1};
            r_fresh_idx <= '0;
        end else begin
            r_known <= n_known;
            if (i_cmd.fresh_step) begin
                r_fresh_idx <= r_fresh_idx + 1'b1;
            end else begin
                r_fresh_idx <= '0;
            end
        end
    end

    // operand read for merge uses target reg as "a"
    logic [RW-1:0] w_a_reg;
    assign w_a_reg = (r_op == krvt_pkg::OP_EXEC) ? r_rs1 : r_tr;

    // shifted remainder needs one extra bit
    assign w_div_trial = {r_rem, r_quo[DW-1]};
    assign w_div_diff  = w_div_trial - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_in_data[1:0];
            r_opc       <= i_in_data[5:2];
            r_rd        <= i_in_data[10:6];
            r_rs1       <= i_in_data[15:11];
            r_rs2       <= i_in_data[20:16];
            r_imm       <= {{(DW-krvt_pkg::IMM_W){i_in_data[40]}}, i_in_data[40:21]};
            r_tr        <= i_in_data[45:41];
            r_inc_known <= i_in_data[46];
            r_inc_val   <= i_in_data[110:47];
        end
        if (i_cmd.fetch_a) begin
            r_ka <= in_range(w_a_reg) && r_known[idx(w_a_reg)];
            r_a  <= in_range(w_a_reg) ? w_rdata : '0;
        end
        if (i_cmd.fetch_b) begin
            r_kb <= in_range(r_rs2) && r_known[idx(r_rs2)];
            r_b  <= in_range(r_rs2) ? w_rdata : '0;
        end
        if (i_cmd.mul_start) begin
            r_mul_acc <= '0;
            r_mul_cnt <= '0;
            r_mul_done <= 1'b0;
        end else if (i_cmd.mul_step) begin
            r_mul_acc <= r_mul_acc + ((r_a * {48'd0, r_b[16*r_mul_cnt +: 16]})
                         << (16 * r_mul_cnt));
            r_mul_cnt <= r_mul_cnt + 1'b1;
            r_mul_done <= (r_mul_cnt == 2'd3);
        end
        if (i_cmd.div_start) begin
            r_quo <= r_a;
            r_rem <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step && r_div_cnt != 7'd64) begin
            if (w_div_trial >= {1'b0, r_b}) begin
                r_rem <= w_div_diff[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= w_div_trial[DW-1:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.commit) begin
            r_touch <= (r_op == krvt_pkg::OP_EXEC) ? r_rd : r_tr;
            r_chg   <= n_chg;
        end
        if (i_cmd.fresh_step) begin
            r_touch <= r_tr;
            r_chg   <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out <= {1'b0,
                      r_chg,
                      in_range(r_touch) ? w_rdata : {DW{1'b0}},
                      in_range(r_touch) && r_known[idx(r_touch)],
                      r_touch};
        end
    end

    assign o_stat.op = r_op;
    assign o_stat.opcode = r_opc;
    assign o_stat.mul_done = r_mul_done;
    assign o_stat.div_done = (r_div_cnt == 7'd64);
    assign o_stat.fresh_done = (r_fresh_idx == (AW+1)'(NUM_REGS - 1));
    assign o_out_data = r_out;

endmodule

// ===== hw/rtl/known_register_value_tracker_unit.sv =====
// Known-register-value tracker: an abstract register file for constant
// propagation. Each entry holds a 64-bit value and a known flag.
// Input channel (s_axis_*): one beat per item; tdata packs op, opcode,
//   dest_reg, src_reg_a, src_reg_b, immediate, target_reg, incoming_known,
//   incoming_value from the low bit up.
// Output channel (m_axis_*): one beat per item; tdata packs touched_reg,
//   now_known, now_value, changed from the low bit up.
// Steps from accept to result valid: operand reads, commit to the file,
//   result read and output load. MUL adds four 64x16 partial products,
//   DIVU/REMU a restoring divider over 64 quotient bits, and fresh replaces
//   the commit with a clearing sweep over the value RAM, one entry a cycle.
//   The next beat is taken in the cycle after the result is loaded.
// One item is in work at a time; s_axis_tready is high only while idle.
// Reset (i_rst_n low, synchronous): only register zero known; afterwards the
//   value RAM is swept to zero with s_axis_tready low.
// When the receiver stalls, the result sits in the output register and the
//   controller holds the next result until it is taken.
module known_register_value_tracker_unit #(
    parameter int NUM_REGS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op, opcode, dest_reg, src_reg_a, src_reg_b, immediate, target_reg,
    // incoming_known, incoming_value (111 bits, padded to 112)
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // touched_reg, now_known, now_value, changed (71 bits, padded to 72)
    output logic [71:0]  m_axis_tdata
);

    krvt_pkg::t_cmd  w_cmd;
    krvt_pkg::t_stat w_stat;
    logic [71:0]     w_out;

    krvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    krvt_dp #(.NUM_REGS(NUM_REGS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_in_data (s_axis_tdata),
        .o_out_data(w_out)
    );

    assign m_axis_tdata = {1'b0, w_out[70:0]};

endmodule
